>>> rtl/record_ring_buffer_two_readers_unit_macros.svh
// Assertion macros for the record ring buffer RTL.
// Used by the top level; the macros expect signals clk and rst in scope.
`ifndef RECORD_RING_BUFFER_TWO_READERS_UNIT_MACROS_SVH
`define RECORD_RING_BUFFER_TWO_READERS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define RRB_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define RRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RRB_ASSERT_IMM(label, ante, cons, msg)

`define RRB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/rrb_pkg.sv
// Shared types, codes and widths for the record ring buffer.
// No dependencies.
`timescale 1ns / 1ps

package rrb_pkg;

  localparam int NUM_BANKS_DEF  = 128;
  localparam int BANK_BYTES_DEF = 1024;
  localparam int HEADER_BYTES   = 2;
  localparam int HEADER_W       = 16;
  localparam int LANES          = 4;
  localparam int LANE_IW        = 2;

  localparam int ACTION_W   = 3;
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 3;
  localparam int SLOT_W     = 7;
  localparam int OFFSET_W   = 10;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 11;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 32;
  localparam int LAG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(4);

  localparam logic [CFG_IDX_W-1:0] REG_LOGGING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NET_LAG = 1'b1;

  localparam logic             LOGGING_RESET = 1'b1;
  localparam logic [LAG_W-1:0] NET_LAG_RESET = LAG_W'(4);

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND       = 3'd0,
    ACT_APPEND_COUNT = 3'd1,
    ACT_COMMIT       = 3'd2,
    ACT_NET_FETCH    = 3'd3,
    ACT_FILE_FETCH   = 3'd4,
    ACT_READ_BYTE    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_RECORD = 2'd1,
    ST_DROPPED   = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

>>> rtl/rrb_in_if.sv
// Input channel of the record ring buffer: valid/ready plus one command item.
// Depends on rrb_pkg.
`timescale 1ns / 1ps

interface rrb_in_if;
  import rrb_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   data_value;
  logic [COUNT_W-1:0]  byte_count;
  logic                link_fresh;
  logic [SLOT_W-1:0]   read_slot;
  logic [OFFSET_W-1:0] read_offset;

  modport source (
    output valid, action, data_value, byte_count, link_fresh, read_slot, read_offset,
    input  ready
  );

  modport sink (
    input  valid, action, data_value, byte_count, link_fresh, read_slot, read_offset,
    output ready
  );
endinterface

>>> rtl/rrb_out_if.sv
// Output channel of the record ring buffer: valid/ready plus one result item.
// Depends on rrb_pkg.
`timescale 1ns / 1ps

interface rrb_out_if;
  import rrb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [LEN_W-1:0]    record_length;
  logic [BYTE_W-1:0]   read_data;
  logic [CNT_W-1:0]    dropped_banks;

  modport source (
    output valid, status, slot, record_length, read_data, dropped_banks,
    input  ready
  );

  modport sink (
    input  valid, status, slot, record_length, read_data, dropped_banks,
    output ready
  );
endinterface

>>> rtl/rrb_ram.sv
// Generic single-clock RAM, one write and one read address, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/record_ring_buffer_two_readers_unit.sv
// Record ring buffer, one writer and two readers: append, commit, fetch, byte read.
// Appends, commits and unused actions: result in the cycle after accept, 1 item per cycle
// while the output is not stalled. Fetches and byte reads: accept moves to S_READ, where
// the registered read of the four byte-lane RAMs loads the result; no item is taken in S_READ.
// Reset (synchronous): counters and read positions cleared, write offset 2, logging on,
// lag limit 4. Store contents undefined after reset; no clearing pass.
`timescale 1ns / 1ps
`include "record_ring_buffer_two_readers_unit_macros.svh"

module record_ring_buffer_two_readers_unit #(
  parameter int NUM_BANKS  = rrb_pkg::NUM_BANKS_DEF,
  parameter int BANK_BYTES = rrb_pkg::BANK_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  rrb_in_if.sink                         in_ch,
  rrb_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rrb_pkg::*;

  localparam int SW         = $clog2(NUM_BANKS);
  localparam int OW         = $clog2(BANK_BYTES + 1);
  localparam int OWX        = OW + 1;
  localparam int TOTAL      = NUM_BANKS * BANK_BYTES;
  localparam int AW         = $clog2(TOTAL + LANES);
  localparam int LANE_DEPTH = (TOTAL + LANES - 1) / LANES;
  localparam int RW         = $clog2(LANE_DEPTH);

  // configuration
  logic             logging_enabled;
  logic [LAG_W-1:0] net_max_lag;

  // writer and reader state
  logic [OW-1:0]    write_offset, write_offset_next;
  logic [CNT_W-1:0] commit_count, commit_count_next;
  logic [SW-1:0]    commit_slot, commit_slot_next;
  logic [AW-1:0]    commit_base, commit_base_next;
  logic [CNT_W-1:0] net_lag, net_lag_next;
  logic [SW-1:0]    net_slot, net_slot_next;
  logic [CNT_W-1:0] file_lag, file_lag_next;
  logic [SW-1:0]    file_slot, file_slot_next;
  logic [CNT_W-1:0] skipped_total;

  state_t state, state_next;

  // pending read
  logic [CNT_W-1:0]   excess, excess_next;
  logic [SW-1:0]      pend_slot, pend_slot_next;
  logic               pend_fetch, pend_fetch_next;
  logic [LANE_IW-1:0] pend_lane;

  // result register
  logic               out_valid;
  status_t            out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [LEN_W-1:0]   out_len;
  logic [BYTE_W-1:0]  out_rdata;
  logic [CNT_W-1:0]   out_dropped;

  logic in_ready, in_fire, need_read, load_out;

  action_t            act;
  logic [COUNT_W-1:0] n_bytes, acc;
  logic [LANES-1:0]   room, wr_en;
  logic [CNT_W-1:0]   wbytes;
  logic [AW-1:0]      a0;
  status_t            res_status;

  logic [LAG_W-1:0] limit;
  logic [SW-1:0]    lim_mod, net_jslot, net_fslot, file_fslot;
  logic             net_jump, net_ok, file_jump, rd_ok;
  logic [CNT_W-1:0] file_excess;
  logic [AW-1:0]    rd_addr;

  logic [LANE_IW-1:0] lane_idx   [LANES];
  logic [AW-1:0]      lane_addr  [LANES];
  logic [RW-1:0]      lane_row   [LANES];
  logic               lane_we    [LANES];
  logic [BYTE_W-1:0]  lane_wdata [LANES];
  logic [BYTE_W-1:0]  lane_rdata [LANES];
  logic [BYTE_W-1:0]  byte0, byte1;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == SW'(NUM_BANKS - 1)) begin
      r = '0;
    end else begin
      r = s + SW'(1);
    end
    return r;
  endfunction

  // lag limit reduced modulo the bank count, as a constant table
  function automatic logic [SW-1:0] mod_banks(input logic [LAG_W-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << LAG_W); i++) begin
      if (v == LAG_W'(i)) begin
        r = SW'(i % NUM_BANKS);
      end
    end
    return r;
  endfunction

  assign in_ready     = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign load_out     = (state == S_READ) || (in_fire && !need_read);

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.slot          = out_slot;
  assign out_ch.record_length = out_len;
  assign out_ch.read_data     = out_rdata;
  assign out_ch.dropped_banks = out_dropped;

  // reader positions
  assign limit     = (net_max_lag == '0) ? LAG_W'(1) : net_max_lag;
  assign lim_mod   = mod_banks(limit);
  assign net_jump  = net_lag > CNT_W'(limit);
  assign net_jslot = (commit_slot >= lim_mod) ? commit_slot - lim_mod :
                     SW'((SW + 1)'(commit_slot) + (SW + 1)'(NUM_BANKS) - (SW + 1)'(lim_mod));
  assign net_fslot = net_jump ? net_jslot : net_slot;
  assign net_ok    = in_ch.link_fresh && logging_enabled && (net_lag != '0);

  assign file_jump   = file_lag > CNT_W'(NUM_BANKS - 1);
  assign file_excess = file_lag - CNT_W'(NUM_BANKS - 1);
  assign file_fslot  = file_jump ? slot_inc(commit_slot) : file_slot;

  assign rd_ok   = (CNT_W'(in_ch.read_slot) < CNT_W'(NUM_BANKS)) &&
                   (CNT_W'(in_ch.read_offset) < CNT_W'(BANK_BYTES));
  assign rd_addr = AW'(CNT_W'(in_ch.read_slot) * CNT_W'(BANK_BYTES) +
                       CNT_W'(in_ch.read_offset));

  always_comb begin
    act        = action_t'(in_ch.action);
    n_bytes    = (in_ch.byte_count > MAX_COUNT) ? MAX_COUNT : in_ch.byte_count;
    wbytes     = in_ch.data_value;
    a0         = commit_base + AW'(write_offset);
    wr_en      = '0;
    acc        = '0;
    need_read  = 1'b0;
    res_status = ST_OK;

    write_offset_next = write_offset;
    commit_count_next = commit_count;
    commit_slot_next  = commit_slot;
    commit_base_next  = commit_base;
    net_lag_next      = net_lag;
    net_slot_next     = net_slot;
    file_lag_next     = file_lag;
    file_slot_next    = file_slot;
    excess_next       = '0;
    pend_slot_next    = '0;
    pend_fetch_next   = 1'b0;

    for (int i = 0; i < LANES; i++) begin
      room[i] = (OWX'(write_offset) + OWX'(i)) < OWX'(BANK_BYTES);
    end

    unique case (act)
      ACT_APPEND, ACT_APPEND_COUNT: begin
        if (act == ACT_APPEND_COUNT) begin
          n_bytes = MAX_COUNT;
          wbytes  = commit_count;
        end
        for (int i = 0; i < LANES; i++) begin
          if (COUNT_W'(i) < n_bytes) begin
            if (room[i]) begin
              wr_en[i] = 1'b1;
              acc      = acc + COUNT_W'(1);
            end else begin
              res_status = ST_DROPPED;
            end
          end
        end
        write_offset_next = write_offset + OW'(acc);
      end
      ACT_COMMIT: begin
        a0 = commit_base;
        if (write_offset > OW'(HEADER_BYTES)) begin
          wr_en             = LANES'(3);
          wbytes            = CNT_W'(HEADER_W'(write_offset));
          commit_count_next = commit_count + CNT_W'(1);
          // wrap of the 32-bit count restarts at bank 0
          if (commit_count == '1) begin
            commit_slot_next = '0;
            commit_base_next = '0;
          end else begin
            commit_slot_next = slot_inc(commit_slot);
            commit_base_next = (commit_slot == SW'(NUM_BANKS - 1)) ? '0 :
                               commit_base + AW'(BANK_BYTES);
          end
          net_lag_next      = net_lag + CNT_W'(1);
          file_lag_next     = file_lag + CNT_W'(1);
          write_offset_next = OW'(HEADER_BYTES);
        end else begin
          res_status = ST_NO_RECORD;
        end
      end
      ACT_NET_FETCH: begin
        a0 = AW'(CNT_W'(net_fslot) * CNT_W'(BANK_BYTES));
        if (net_ok) begin
          need_read       = 1'b1;
          pend_fetch_next = 1'b1;
          pend_slot_next  = net_fslot;
          net_slot_next   = slot_inc(net_fslot);
          net_lag_next    = (net_jump ? CNT_W'(limit) : net_lag) - CNT_W'(1);
        end else begin
          res_status = ST_NO_RECORD;
        end
      end
      ACT_FILE_FETCH: begin
        a0 = AW'(CNT_W'(file_fslot) * CNT_W'(BANK_BYTES));
        if (file_lag != '0) begin
          need_read       = 1'b1;
          pend_fetch_next = 1'b1;
          pend_slot_next  = file_fslot;
          file_slot_next  = slot_inc(file_fslot);
          file_lag_next   = (file_jump ? CNT_W'(NUM_BANKS - 1) : file_lag) - CNT_W'(1);
          excess_next     = file_jump ? file_excess : '0;
        end else begin
          res_status = ST_NO_RECORD;
        end
      end
      ACT_READ_BYTE: begin
        a0 = rd_addr;
        if (rd_ok) begin
          need_read = 1'b1;
        end else begin
          res_status = ST_NO_RECORD;
        end
      end
      default: begin
      end
    endcase

    // byte i of the access sits in lane (a0 + i) mod 4
    for (int l = 0; l < LANES; l++) begin
      lane_idx[l]   = LANE_IW'(l) - a0[LANE_IW-1:0];
      lane_addr[l]  = a0 + AW'(lane_idx[l]);
      lane_row[l]   = RW'(lane_addr[l] >> LANE_IW);
      lane_we[l]    = in_fire && wr_en[lane_idx[l]];
      lane_wdata[l] = wbytes[BYTE_W * lane_idx[l] +: BYTE_W];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LANE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (lane_we[l]),
      .waddr (lane_row[l]),
      .wdata (lane_wdata[l]),
      .raddr (lane_row[l]),
      .rdata (lane_rdata[l])
    );
  end

  assign byte0 = lane_rdata[pend_lane];
  assign byte1 = lane_rdata[pend_lane + LANE_IW'(1)];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && need_read) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      logging_enabled <= LOGGING_RESET;
      net_max_lag     <= NET_LAG_RESET;
      write_offset    <= OW'(HEADER_BYTES);
      commit_count    <= '0;
      commit_slot     <= '0;
      commit_base     <= '0;
      net_lag         <= '0;
      net_slot        <= '0;
      file_lag        <= '0;
      file_slot       <= '0;
      skipped_total   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOGGING: logging_enabled <= cfg_data[0];
          REG_NET_LAG: net_max_lag     <= cfg_data;
        endcase
      end
      if (in_fire) begin
        write_offset <= write_offset_next;
        commit_count <= commit_count_next;
        commit_slot  <= commit_slot_next;
        commit_base  <= commit_base_next;
        net_lag      <= net_lag_next;
        net_slot     <= net_slot_next;
        file_lag     <= file_lag_next;
        file_slot    <= file_slot_next;
      end
      if (state == S_READ) begin
        skipped_total <= skipped_total + excess;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      excess     <= excess_next;
      pend_slot  <= pend_slot_next;
      pend_fetch <= pend_fetch_next;
      pend_lane  <= a0[LANE_IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      out_status  <= ST_OK;
      out_slot    <= pend_fetch ? SLOT_W'(pend_slot) : '0;
      out_len     <= pend_fetch ? LEN_W'({byte1, byte0}) : '0;
      out_rdata   <= pend_fetch ? '0 : byte0;
      out_dropped <= skipped_total + excess;
    end else if (in_fire && !need_read) begin
      out_status  <= res_status;
      out_slot    <= '0;
      out_len     <= '0;
      out_rdata   <= '0;
      out_dropped <= skipped_total;
    end
  end

  `RRB_ASSERT_IMM(a_read_out_free, state == S_READ, !out_valid, "result register busy during read")
  `RRB_ASSERT_NEXT(a_read_follows, in_fire && need_read, state == S_READ, "read item lost its read cycle")
  `RRB_ASSERT_NEXT(a_read_loads, state == S_READ, out_valid, "read cycle produced no result")
  `RRB_ASSERT_IMM(a_offset_range, 1'b1, write_offset >= OW'(HEADER_BYTES) && write_offset <= OW'(BANK_BYTES), "write offset out of range")

endmodule
